// File: rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int unsigned HEAP_BYTES_DEF   = 65536;
  localparam int unsigned HEADER_BYTES_DEF = 24;
  localparam int unsigned GRAN_BYTES       = 8;
  localparam int unsigned GRAN_SHIFT       = $clog2(GRAN_BYTES);
  // block size word: size in bytes with the allocated flag in bit 0
  localparam int unsigned SIZE_W           = 17;
  localparam int unsigned DATA_W           = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_CHK,
    ST_A_UNL,
    ST_A_CARVE,
    ST_F_CHK,
    ST_F_LINK,
    ST_DONE
  } ffa_state_e;

  typedef struct packed {
    logic rd_en;
    logic sz_we;
    logic nx_we;
    logic pv_we;
  } ffa_mem_ctl_t;

endpackage

// File: rtl/ffa_if.sv
interface ffa_req_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DATA_W-1:0] req_size;
  logic [DATA_W-1:0] free_addr;

  modport source (output valid, cmd, req_size, free_addr, input ready);
  modport sink   (input valid, cmd, req_size, free_addr, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] payload_addr;
  logic              ok;

  modport source (output valid, payload_addr, ok, input ready);
  modport sink   (input valid, payload_addr, ok, output ready);
endinterface

// File: rtl/first_fit_free_list_allocator_top.sv
// Allocate: the request walks the free list node by node; a fit is unlinked, with a further
// step to relink the successor unless the fit is the list tail; a carve or a failure follows
// the walk. Free: a check and then a link step, the link step skipped if the list is empty or
// the block is not allocated, and the check skipped if the address is out of range. A new
// request is taken the cycle after the result is registered. Reset: list head and break
// reset at once; a clearing pass then writes every size word, during which no item is taken.
module first_fit_free_list_allocator_top import ffa_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ffa_req_if.sink  req_i,
  ffa_rsp_if.source rsp_o
);

  localparam int unsigned HDR_AL = ((HEADER_BYTES + GRAN_BYTES - 1) / GRAN_BYTES) * GRAN_BYTES;
  localparam int unsigned NBLK   = HEAP_BYTES / GRAN_BYTES;
  localparam int unsigned GW     = $clog2(NBLK);
  localparam int unsigned STW    = GW + 1;
  localparam int unsigned BW     = $clog2(HEAP_BYTES + 1);
  localparam int unsigned EW     = ((BW > SIZE_W) ? BW : SIZE_W) + 1;

  ffa_state_e        state_q, state_d;
  logic [GW-1:0]     head_q, head_d;
  logic [BW-1:0]     brk_q, brk_d;
  logic [GW-1:0]     clr_q, clr_d;
  logic [STW-1:0]    steps_q, steps_d;
  logic [SIZE_W-1:0] need_q, need_d;
  logic [GW-1:0]     cur_q, cur_d;
  logic [GW-1:0]     pv_q, pv_d;
  logic [GW-1:0]     nx_q, nx_d;
  logic [GW-1:0]     hn_q, hn_d;
  logic [DATA_W-1:0] res_addr_q, res_addr_d;
  logic              res_ok_q, res_ok_d;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_addr_q;
  logic              out_ok_q;
  logic              out_load;

  ffa_mem_ctl_t      mem_ctl;
  logic [GW-1:0]     rd_addr;
  logic [GW-1:0]     sz_waddr;
  logic [SIZE_W-1:0] sz_wdata;
  logic [GW-1:0]     lk_waddr;
  logic [GW-1:0]     nx_wdata;
  logic [GW-1:0]     pv_wdata;
  logic [SIZE_W-1:0] sz_rd;
  logic [GW-1:0]     nx_rd;
  logic [GW-1:0]     pv_rd;

  logic [SIZE_W-1:0] req_round;
  logic [DATA_W-1:0] free_off;
  logic [EW-1:0]     free_blk;
  logic              free_legal;
  logic [STW-1:0]    steps_nx;
  logic [EW-1:0]     carve_end;
  logic [EW-1:0]     blk_addr;
  logic [EW-1:0]     brk_addr;

  ffa_store #(
    .DEPTH (NBLK),
    .AW    (GW)
  ) u_store (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .rd_addr_i  (rd_addr),
    .sz_waddr_i (sz_waddr),
    .sz_wdata_i (sz_wdata),
    .lk_waddr_i (lk_waddr),
    .nx_wdata_i (nx_wdata),
    .pv_wdata_i (pv_wdata),
    .sz_rdata_o (sz_rd),
    .nx_rdata_o (nx_rd),
    .pv_rdata_o (pv_rd)
  );

  // request rounded up to whole granules, plus the aligned header
  assign req_round = ((SIZE_W'(req_i.req_size) + SIZE_W'(GRAN_BYTES - 1))
                      & ~SIZE_W'(GRAN_BYTES - 1)) + SIZE_W'(HDR_AL);
  assign free_off  = req_i.free_addr - DATA_W'(HDR_AL);
  assign free_blk  = EW'(free_off) >> GRAN_SHIFT;
  assign free_legal = (req_i.free_addr >= DATA_W'(HDR_AL))
                   && (req_i.free_addr[GRAN_SHIFT-1:0] == '0)
                   && (free_off != '0)
                   && (EW'(free_off) < EW'(brk_q));
  assign steps_nx  = steps_q + STW'(1);
  assign carve_end = EW'(brk_q) + EW'(need_q);
  assign blk_addr  = (EW'(cur_q) << GRAN_SHIFT) + EW'(HDR_AL);
  assign brk_addr  = EW'(brk_q) + EW'(HDR_AL);

  assign req_i.ready = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    brk_d      = brk_q;
    clr_d      = clr_q;
    steps_d    = steps_q;
    need_d     = need_q;
    cur_d      = cur_q;
    pv_d       = pv_q;
    nx_d       = nx_q;
    hn_d       = hn_q;
    res_addr_d = res_addr_q;
    res_ok_d   = res_ok_q;
    mem_ctl    = '0;
    rd_addr    = cur_q;
    sz_waddr   = cur_q;
    sz_wdata   = sz_rd;
    lk_waddr   = cur_q;
    nx_wdata   = nx_rd;
    pv_wdata   = pv_rd;

    unique case (state_q)
      ST_CLEAR: begin
        mem_ctl.sz_we = 1'b1;
        sz_waddr      = clr_q;
        sz_wdata      = (clr_q == '0) ? SIZE_W'(HDR_AL) : '0;
        clr_d         = clr_q + GW'(1);
        if (clr_q == GW'(NBLK - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_i.valid) begin
          res_addr_d = '0;
          res_ok_d   = 1'b0;
          if (req_i.cmd == CMD_ALLOC) begin
            need_d  = req_round;
            steps_d = '0;
            if (head_q != '0) begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = head_q;
              cur_d         = head_q;
              state_d       = ST_A_CHK;
            end else begin
              state_d = ST_A_CARVE;
            end
          end else if (free_legal) begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = free_blk[GW-1:0];
            cur_d         = free_blk[GW-1:0];
            state_d       = ST_F_CHK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_A_CHK: begin
        if (sz_rd >= need_q) begin
          // take the node: mark allocated, bypass it from its predecessor
          mem_ctl.sz_we = 1'b1;
          sz_wdata      = sz_rd | SIZE_W'(1);
          if (pv_rd != '0) begin
            mem_ctl.nx_we = 1'b1;
            lk_waddr      = pv_rd;
            nx_wdata      = nx_rd;
          end else begin
            head_d = nx_rd;
          end
          pv_d       = pv_rd;
          nx_d       = nx_rd;
          res_addr_d = blk_addr[DATA_W-1:0];
          res_ok_d   = 1'b1;
          state_d    = (nx_rd != '0) ? ST_A_UNL : ST_DONE;
        end else if (nx_rd == '0 || steps_nx == STW'(NBLK)) begin
          state_d = ST_A_CARVE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = nx_rd;
          cur_d         = nx_rd;
          steps_d       = steps_nx;
        end
      end

      ST_A_UNL: begin
        mem_ctl.pv_we = 1'b1;
        lk_waddr      = nx_q;
        pv_wdata      = pv_q;
        state_d       = ST_DONE;
      end

      ST_A_CARVE: begin
        if (carve_end <= EW'(HEAP_BYTES)) begin
          mem_ctl.sz_we = 1'b1;
          sz_waddr      = brk_q[GW+GRAN_SHIFT-1:GRAN_SHIFT];
          sz_wdata      = need_q | SIZE_W'(1);
          brk_d         = carve_end[BW-1:0];
          res_addr_d    = brk_addr[DATA_W-1:0];
          res_ok_d      = 1'b1;
        end
        state_d = ST_DONE;
      end

      ST_F_CHK: begin
        if (sz_rd[0]) begin
          // clear the allocated flag and push the block onto the front of the list as the new head
          mem_ctl.sz_we = 1'b1;
          sz_wdata      = sz_rd & ~SIZE_W'(1);
          mem_ctl.nx_we = 1'b1;
          mem_ctl.pv_we = 1'b1;
          nx_wdata      = head_q;
          pv_wdata      = '0;
          head_d        = cur_q;
          hn_d          = head_q;
          res_ok_d      = 1'b1;
          state_d       = (head_q != '0) ? ST_F_LINK : ST_DONE;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_F_LINK: begin
        mem_ctl.pv_we = 1'b1;
        lk_waddr      = hn_q;
        pv_wdata      = cur_q;
        state_d       = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      head_q      <= '0;
      brk_q       <= BW'(HDR_AL);
      clr_q       <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      brk_q   <= brk_d;
      clr_q   <= clr_d;
      steps_q <= steps_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    need_q     <= need_d;
    cur_q      <= cur_d;
    pv_q       <= pv_d;
    nx_q       <= nx_d;
    hn_q       <= hn_d;
    res_addr_q <= res_addr_d;
    res_ok_q   <= res_ok_d;
    if (out_load) begin
      out_addr_q <= res_addr_q;
      out_ok_q   <= res_ok_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.payload_addr = out_addr_q;
  assign rsp_o.ok           = out_ok_q;

  // the break only moves on a carve
  a_brk_carve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (brk_q != $past(brk_q)) |-> ($past(state_q) == ST_A_CARVE))
    else $error("break pointer moved outside a carve");

  // the list head only moves when a node is taken or a block is pushed
  a_head_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != $past(head_q)) |->
      ($past(state_q) == ST_A_CHK || $past(state_q) == ST_F_CHK))
    else $error("list head moved outside an unlink or a push");

  // the walk never visits more nodes than there are granules
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_A_CHK) |-> (steps_q < STW'(NBLK)))
    else $error("free-list walk exceeded its bound");

  // a finished result waits in DONE until the output register frees up
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !rsp_o.ready) |=> (state_q == ST_DONE))
    else $error("result left DONE while the output register was full");

endmodule

// File: rtl/ffa_store.sv
module ffa_store import ffa_pkg::*; #(
  parameter int unsigned DEPTH = HEAP_BYTES_DEF / GRAN_BYTES,
  parameter int unsigned AW    = $clog2(HEAP_BYTES_DEF / GRAN_BYTES)
) (
  input  logic              clk_i,
  input  ffa_mem_ctl_t      ctl_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [AW-1:0]     sz_waddr_i,
  input  logic [SIZE_W-1:0] sz_wdata_i,
  input  logic [AW-1:0]     lk_waddr_i,
  input  logic [AW-1:0]     nx_wdata_i,
  input  logic [AW-1:0]     pv_wdata_i,
  output logic [SIZE_W-1:0] sz_rdata_o,
  output logic [AW-1:0]     nx_rdata_o,
  output logic [AW-1:0]     pv_rdata_o
);

  logic [SIZE_W-1:0] sz_mem [DEPTH];
  // link word: next in the upper half, prev in the lower half
  logic [2*AW-1:0]   lk_mem [DEPTH];
  logic [SIZE_W-1:0] sz_rdata_q;
  logic [2*AW-1:0]   lk_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.sz_we) begin
      sz_mem[sz_waddr_i] <= sz_wdata_i;
    end
    if (ctl_i.rd_en) begin
      sz_rdata_q <= sz_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.nx_we) begin
      lk_mem[lk_waddr_i][2*AW-1:AW] <= nx_wdata_i;
    end
    if (ctl_i.pv_we) begin
      lk_mem[lk_waddr_i][AW-1:0] <= pv_wdata_i;
    end
    if (ctl_i.rd_en) begin
      lk_rdata_q <= lk_mem[rd_addr_i];
    end
  end

  assign sz_rdata_o = sz_rdata_q;
  assign nx_rdata_o = lk_rdata_q[2*AW-1:AW];
  assign pv_rdata_o = lk_rdata_q[AW-1:0];

endmodule
